// ----- hw/rtl/bmp_24bpp_pixel_decoder_defines.svh -----
// assertion macros shared by the bmp pixel decoder rtl
// expects signals named clk and rst in the including scope
`ifndef BMP_24BPP_PIXEL_DECODER_DEFINES_SVH
`define BMP_24BPP_PIXEL_DECODER_DEFINES_SVH

// expression must never be true outside reset
`define BMPD_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BMPD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bmpd_pkg.sv -----
// shared types and constants for the bmp 24 bpp pixel decoder
// no dependencies
`timescale 1ns / 1ps

package bmpd_pkg;

  // parse phases of the front end
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE
  } bmpd_phase_t;

  // work codes passed from front end to back end
  typedef enum logic [1:0] {
    OP_BLUE,
    OP_GREEN,
    OP_PIXEL,
    OP_ERROR
  } bmpd_op_t;

  // result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // header byte positions
  localparam logic [4:0] POS_OFFSET = 5'd10;
  localparam logic [4:0] POS_WIDTH  = 5'd18;
  localparam logic [4:0] POS_HEIGHT = 5'd22;
  localparam logic [4:0] POS_BPP    = 5'd28;
  localparam logic [4:0] POS_CHECK  = 5'd29;
  localparam logic [31:0] HDR_END   = 32'd30;

  localparam logic [15:0] BPP_24 = 16'd24;

  // one queued work word
  typedef struct packed {
    bmpd_op_t    op;
    logic [7:0]  data;
    logic [11:0] column;
    logic [11:0] row;
    logic        last;
  } bmpd_entry_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } bmpd_qstat_t;

endpackage

// ----- hw/rtl/bmp_24bpp_pixel_decoder.sv -----
// channel  | handshake            | payload
// input    | in_valid / in_ready  | data_byte, start_of_file
// output   | out_valid / out_ready| result_kind, red, green, blue, column, row, last
//
// one file byte is taken per clock while the queue has room; a result passes
// through the queue and then the output register when no earlier result waits
// on an output stall blue and green words still drain, so bytes keep flowing
// until a result word waits at the head of a full queue
// reset clears the parse: the first byte after reset counts as byte 0
// depends on bmpd_pkg, bmpd_queue, bmpd_front, bmpd_back and the defines header
`timescale 1ns / 1ps
`include "bmp_24bpp_pixel_decoder_defines.svh"

module bmp_24bpp_pixel_decoder
  import bmpd_pkg::*;
#(
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_HEIGHT  = 4096,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [11:0] column,
  output logic [11:0] row,
  output logic        last
);

  bmpd_qstat_t q_stat;
  bmpd_entry_t q_in;
  bmpd_entry_t q_head;
  logic        q_push;
  logic        q_pop;

  // byte parser
  bmpd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .qstat         (q_stat),
    .push          (q_push),
    .entry         (q_in)
  );

  // work queue
  bmpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .pop_entry  (q_head),
    .status     (q_stat)
  );

  // result builder
  bmpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .qstat       (q_stat),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .column      (column),
    .row         (row),
    .last        (last)
  );

  // checks
  `BMPD_ASSERT_NEVER(a_no_overflow, q_push && q_stat.full, "push into full queue")
  `BMPD_ASSERT_NEVER(a_no_underflow, q_pop && q_stat.empty, "pop from empty queue")
  `BMPD_ASSERT_IMPLIES(a_error_shape, out_valid && (result_kind == KIND_ERROR),
    last && (column == '0) && (row == '0) && (red == '0), "malformed error result")

endmodule

// ----- hw/rtl/bmpd_queue.sv -----
// short in-order queue of work words between front and back end
// depends on bmpd_pkg
`timescale 1ns / 1ps

module bmpd_queue
  import bmpd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  bmpd_entry_t push_entry,
  input  logic        pop,
  output bmpd_entry_t pop_entry,
  output bmpd_qstat_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bmpd_entry_t    entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  // pointer advance with wrap
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) r = '0;
    else r = p + PW'(1);
    return r;
  endfunction

  assign pop_entry    = entries[rd_ptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

// ----- hw/rtl/bmpd_front.sv -----
// front end: takes file bytes, parses the header, skips to pixel data,
// tracks pixel position and padding, queues work words. depends on bmpd_pkg
`timescale 1ns / 1ps

module bmpd_front
  import bmpd_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  input  bmpd_qstat_t qstat,
  output logic        push,
  output bmpd_entry_t entry
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [1:0] BIP_RED = 2'd2;

  bmpd_phase_t    phase, phase_next, phase_cur;
  logic [31:0]    pos, pos_next, pos_cur;
  logic [1:0]     bip, bip_next;
  logic [1:0]     pad_left, pad_next;
  logic [CW-1:0]  col, col_next;
  logic [RW-1:0]  top, top_next;
  logic [CW-1:0]  width_m1;

  // header fields
  logic [31:0]    offset;
  logic [31:0]    width;
  logic [31:0]    height;
  logic [7:0]     bpp_lo;

  logic           accept;
  logic           at_check;
  logic           bad;
  logic           row_end;
  logic           img_end;
  logic           pixel_emit;
  logic [4:0]     hdr_idx;
  logic [1:0]     lane;
  logic [31:0]    width_m1_w;
  logic [31:0]    height_m1_w;
  logic [31:0]    col_w;
  logic [31:0]    top_w;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // a start mark restarts the parse on this byte
  assign phase_cur = start_of_file ? PH_HEADER : phase;
  assign pos_cur   = start_of_file ? '0 : pos;
  assign hdr_idx   = pos_cur[4:0];
  assign lane      = hdr_idx[1:0] - POS_OFFSET[1:0];
  assign at_check  = (pos_cur == 32'(POS_CHECK));

  // header check, bpp high byte arrives on this very byte
  assign bad = ({data_byte, bpp_lo} != BPP_24)
            || (height == '0) || height[31]
            || (width == '0) || width[31]
            || (width > 32'(MAX_WIDTH))
            || (height > 32'(MAX_HEIGHT));

  assign width_m1_w  = width - 32'd1;
  assign height_m1_w = height - 32'd1;

  assign row_end    = (col == width_m1);
  assign img_end    = row_end && (top == '0);
  assign pixel_emit = (pad_left == '0) && (bip == BIP_RED);

  assign col_w = 32'(col);
  assign top_w = 32'(top);

  // saturating byte position
  always_comb begin
    pos_next = pos;
    if (accept) begin
      pos_next = (pos_cur == '1) ? pos_cur : pos_cur + 32'd1;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase_cur)
        PH_HEADER: begin
          if (!at_check) phase_next = PH_HEADER;
          else if (bad) phase_next = PH_DONE;
          else if (offset <= HDR_END) phase_next = PH_PIXELS;
          else phase_next = PH_SKIP;
        end
        PH_SKIP: begin
          phase_next = (pos_next >= offset) ? PH_PIXELS : PH_SKIP;
        end
        PH_PIXELS: begin
          phase_next = (pixel_emit && img_end) ? PH_DONE : PH_PIXELS;
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  // pixel counters and queued work words
  always_comb begin
    bip_next     = bip;
    pad_next     = pad_left;
    col_next     = col;
    top_next     = top;
    push         = 1'b0;
    entry.op     = OP_BLUE;
    entry.data   = data_byte;
    entry.column = '0;
    entry.row    = '0;
    entry.last   = 1'b0;
    if (accept) begin
      unique case (phase_cur)
        PH_HEADER: begin
          if (at_check) begin
            bip_next = '0;
            pad_next = '0;
            col_next = '0;
            top_next = height_m1_w[RW-1:0];
            if (bad) begin
              push       = 1'b1;
              entry.op   = OP_ERROR;
              entry.data = '0;
              entry.last = 1'b1;
            end
          end
        end
        PH_PIXELS: begin
          if (pad_left != '0) begin
            pad_next = pad_left - 2'd1;
          end else if (bip == 2'd0) begin
            push     = 1'b1;
            entry.op = OP_BLUE;
            bip_next = 2'd1;
          end else if (bip == 2'd1) begin
            push     = 1'b1;
            entry.op = OP_GREEN;
            bip_next = BIP_RED;
          end else begin
            push         = 1'b1;
            entry.op     = OP_PIXEL;
            entry.column = col_w[11:0];
            entry.row    = top_w[11:0];
            entry.last   = img_end;
            bip_next     = 2'd0;
            if (!img_end) begin
              if (row_end) begin
                col_next = '0;
                top_next = top - RW'(1);
                // row padding (4 - 3*width mod 4) mod 4 equals width mod 4
                pad_next = width[1:0];
              end else begin
                col_next = col + CW'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      pos      <= '0;
      bip      <= '0;
      pad_left <= '0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      bip      <= bip_next;
      pad_left <= pad_next;
    end
  end

  // header capture and geometry
  always_ff @(posedge clk) begin
    col <= col_next;
    top <= top_next;
    if (accept && phase_cur == PH_HEADER) begin
      case (hdr_idx) inside
        [POS_OFFSET : POS_OFFSET + 5'd3]: offset[{lane, 3'b000} +: 8] <= data_byte;
        [POS_WIDTH : POS_WIDTH + 5'd3]:   width[{lane, 3'b000} +: 8]  <= data_byte;
        [POS_HEIGHT : POS_HEIGHT + 5'd3]: height[{lane, 3'b000} +: 8] <= data_byte;
        POS_BPP:                          bpp_lo <= data_byte;
        default: begin
        end
      endcase
      if (at_check) begin
        width_m1 <= width_m1_w[CW-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/bmpd_back.sv -----
// back end: gathers blue and green, forms pixel and error results
// in an output register. depends on bmpd_pkg
`timescale 1ns / 1ps

module bmpd_back
  import bmpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  bmpd_entry_t head,
  input  bmpd_qstat_t qstat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [11:0] column,
  output logic [11:0] row,
  output logic        last
);

  logic [7:0] held_blue;
  logic [7:0] held_green;
  logic       out_free;
  logic       is_result;

  assign out_free  = !out_valid || out_ready;
  assign is_result = (head.op == OP_PIXEL) || (head.op == OP_ERROR);
  // component words never wait on the output register
  assign pop = !qstat.empty && (!is_result || out_free);

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // held components and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (head.op)
        OP_BLUE: begin
          held_blue <= head.data;
        end
        OP_GREEN: begin
          held_green <= head.data;
        end
        OP_PIXEL: begin
          result_kind <= KIND_PIXEL;
          red         <= head.data;
          green       <= held_green;
          blue        <= held_blue;
          column      <= head.column;
          row         <= head.row;
          last        <= head.last;
        end
        OP_ERROR: begin
          result_kind <= KIND_ERROR;
          red         <= '0;
          green       <= '0;
          blue        <= '0;
          column      <= '0;
          row         <= '0;
          last        <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
